// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_AT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT_CLK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cnp_pkg.sv -----
// Shared types and constants of the cpio newc archive parser.
`timescale 1ns / 1ps

package cnp_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int HEADER_BYTES          = 110;
    localparam int OFF_BITS              = $clog2(HEADER_BYTES);
    localparam int SIZE_BITS             = 32;
    localparam int CNT_BITS              = 32;
    localparam int LEN_BITS              = 32;
    localparam int BYTE_BITS             = 8;
    localparam int KIND_BITS             = 3;
    localparam int VERDICT_BITS          = 3;
    localparam int TYPE_BITS             = 4;
    localparam int ALIGN_BITS            = 2;
    localparam int ALIGN_BYTES           = 4;
    localparam int HEX_DIGITS            = 8;
    localparam int TDATA_BITS            = 72;
    localparam int TUSER_BITS            = KIND_BITS + VERDICT_BITS;

    localparam int OFF_MODE  = 14;
    localparam int OFF_FSIZE = 54;
    localparam int OFF_NSIZE = 94;

    localparam int OFF_BOUND_END   = OFF_NSIZE + HEX_DIGITS;
    localparam int OFF_BOUND_NAME  = OFF_BOUND_END + 1;
    localparam int OFF_BOUND_ALIGN = OFF_BOUND_END + 2;
    localparam int OFF_BOUND_CHECK = OFF_BOUND_END + 3;

    localparam int TRAILER_LEN = 11;

    localparam logic [TYPE_BITS-1:0] TYPE_DIR = 4'h4;
    localparam logic [TYPE_BITS-1:0] TYPE_REG = 4'h8;

    localparam logic [KIND_BITS-1:0] EV_NAME      = 3'd0;
    localparam logic [KIND_BITS-1:0] EV_NAME_LAST = 3'd1;
    localparam logic [KIND_BITS-1:0] EV_DATA      = 3'd2;
    localparam logic [KIND_BITS-1:0] EV_DATA_LAST = 3'd3;
    localparam logic [KIND_BITS-1:0] EV_STOP      = 3'd4;

    localparam logic [VERDICT_BITS-1:0] VD_MKDIR     = 3'd0;
    localparam logic [VERDICT_BITS-1:0] VD_FILE      = 3'd1;
    localparam logic [VERDICT_BITS-1:0] VD_IGNORED   = 3'd2;
    localparam logic [VERDICT_BITS-1:0] VD_TRAILER   = 3'd3;
    localparam logic [VERDICT_BITS-1:0] VD_SHORT     = 3'd4;
    localparam logic [VERDICT_BITS-1:0] VD_NAME_OVER = 3'd5;

    typedef enum logic [5:0] {
        PH_HEADER   = 6'b000001,
        PH_NAME     = 6'b000010,
        PH_NAME_PAD = 6'b000100,
        PH_DATA     = 6'b001000,
        PH_DATA_PAD = 6'b010000,
        PH_STOPPED  = 6'b100000
    } cnp_phase_t;

    typedef struct packed {
        logic                restart;
        logic                step;
        logic [OFF_BITS-1:0] off;
    } cnp_hdr_ctl_t;

    typedef struct packed {
        logic overrun;
        logic fits;
    } cnp_bound_t;

    typedef struct packed {
        logic [SIZE_BITS-1:0]    entry_name_size;
        logic [SIZE_BITS-1:0]    entry_file_size;
        logic [VERDICT_BITS-1:0] verdict;
        logic [BYTE_BITS-1:0]    byte_out;
        logic [KIND_BITS-1:0]    event_kind;
    } cnp_result_t;

endpackage

// ----- sv/cnp_hex_field.sv -----
// Hex digit accumulator and capture of the mode, file size and name size fields.
`timescale 1ns / 1ps

module cnp_hex_field
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  cnp_pkg::cnp_hdr_ctl_t                      hdr_ctl,
    input  logic [cnp_pkg::BYTE_BITS-1:0]              byte_in,
    output logic [cnp_pkg::TYPE_BITS-1:0]              mode_type,
    output logic [cnp_pkg::SIZE_BITS-1:0]              file_size,
    output logic [cnp_pkg::SIZE_BITS-1:0]              name_size
);
    import cnp_pkg::*;

    logic [SIZE_BITS-1:0] acc_reg, acc_next;
    logic                 ended_reg, ended_next;
    logic [TYPE_BITS-1:0] mode_reg, mode_next;
    logic [SIZE_BITS-1:0] fsize_reg, fsize_next;
    logic [SIZE_BITS-1:0] nsize_reg, nsize_next;
    logic                 is_hex;
    logic [3:0]           digit;
    logic                 field_start;
    logic [SIZE_BITS-1:0] acc_base;
    logic                 ended_base;

    always_comb
    begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (byte_in >= "0" && byte_in <= "9")
        begin
            digit = 4'(byte_in - "0");
        end
        else if (byte_in >= "a" && byte_in <= "f")
        begin
            digit = 4'(byte_in - "a" + 8'd10);
        end
        else if (byte_in >= "A" && byte_in <= "F")
        begin
            digit = 4'(byte_in - "A" + 8'd10);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    always_comb
    begin
        field_start = (hdr_ctl.off == OFF_BITS'(OFF_MODE)) ||
                      (hdr_ctl.off == OFF_BITS'(OFF_FSIZE)) ||
                      (hdr_ctl.off == OFF_BITS'(OFF_NSIZE));
        acc_base    = field_start ? '0 : acc_reg;
        ended_base  = field_start ? 1'b0 : ended_reg;
        acc_next    = acc_reg;
        ended_next  = ended_reg;
        mode_next   = mode_reg;
        fsize_next  = fsize_reg;
        nsize_next  = nsize_reg;
        if (hdr_ctl.step)
        begin
            acc_next   = acc_base;
            ended_next = ended_base;
            if (!ended_base)
            begin
                if (is_hex)
                begin
                    acc_next = {acc_base[SIZE_BITS-5:0], digit};
                end
                else
                begin
                    ended_next = 1'b1;
                end
            end
            if (hdr_ctl.off == OFF_BITS'(OFF_MODE + HEX_DIGITS - 1))
            begin
                mode_next = acc_next[15:12];
            end
            if (hdr_ctl.off == OFF_BITS'(OFF_FSIZE + HEX_DIGITS - 1))
            begin
                fsize_next = acc_next;
            end
            if (hdr_ctl.off == OFF_BITS'(OFF_NSIZE + HEX_DIGITS - 1))
            begin
                nsize_next = acc_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            ended_reg <= 1'b0;
            mode_reg  <= '0;
            fsize_reg <= '0;
            nsize_reg <= '0;
        end
        else if (hdr_ctl.restart)
        begin
            acc_reg   <= '0;
            ended_reg <= 1'b0;
            mode_reg  <= '0;
            fsize_reg <= '0;
            nsize_reg <= '0;
        end
        else
        begin
            acc_reg   <= acc_next;
            ended_reg <= ended_next;
            mode_reg  <= mode_next;
            fsize_reg <= fsize_next;
            nsize_reg <= nsize_next;
        end
    end

    assign mode_type = mode_reg;
    assign file_size = fsize_reg;
    assign name_size = nsize_reg;

endmodule

// ----- sv/cnp_bound_calc.sv -----
// Name end and data end bounds, worked out over the last header bytes.
`timescale 1ns / 1ps

module cnp_bound_calc
#(
    parameter int POSITION_BITS = cnp_pkg::POSITION_BITS_DEFAULT
)
(
    input  logic                             clk,
    input  cnp_pkg::cnp_hdr_ctl_t            hdr_ctl,
    input  logic [POSITION_BITS-1:0]         position,
    input  logic [cnp_pkg::SIZE_BITS-1:0]    name_size,
    input  logic [cnp_pkg::SIZE_BITS-1:0]    file_size,
    input  logic [cnp_pkg::LEN_BITS-1:0]     archive_length,
    output cnp_pkg::cnp_bound_t              bound
);
    import cnp_pkg::*;

    localparam int LW = (POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS;
    localparam int EW = LW + 2;
    localparam logic [POSITION_BITS:0] END_STEP =
        (POSITION_BITS + 1)'(HEADER_BYTES - OFF_BOUND_END);
    localparam logic [EW-1:0] ALIGN_MASK = EW'(ALIGN_BYTES - 1);

    logic [POSITION_BITS-1:0] end_pos_reg;
    logic [EW-1:0]            name_end_reg;
    logic [EW-1:0]            aligned_reg;
    cnp_bound_t               bound_reg;
    logic [POSITION_BITS:0]   end_sum;
    logic [EW-1:0]            len_ext;
    logic [EW-1:0]            data_end;

    always_comb
    begin
        end_sum  = {1'b0, position} + END_STEP;
        len_ext  = EW'(archive_length);
        data_end = aligned_reg + EW'(file_size);
    end

    always_ff @(posedge clk)
    begin
        if (hdr_ctl.step && hdr_ctl.off == OFF_BITS'(OFF_BOUND_END))
        begin
            end_pos_reg <= end_sum[POSITION_BITS] ? '1 : end_sum[POSITION_BITS-1:0];
        end
        if (hdr_ctl.step && hdr_ctl.off == OFF_BITS'(OFF_BOUND_NAME))
        begin
            name_end_reg <= EW'(end_pos_reg) + EW'(name_size);
        end
        if (hdr_ctl.step && hdr_ctl.off == OFF_BITS'(OFF_BOUND_ALIGN))
        begin
            aligned_reg <= (name_end_reg + ALIGN_MASK) & ~ALIGN_MASK;
        end
        if (hdr_ctl.step && hdr_ctl.off == OFF_BITS'(OFF_BOUND_CHECK))
        begin
            bound_reg.overrun <= aligned_reg > len_ext;
            bound_reg.fits    <= data_end <= len_ext;
        end
    end

    assign bound = bound_reg;

endmodule

// ----- sv/cnp_engine.sv -----
// Parse phase sequencer: position, counters, entry verdict and result building.
`timescale 1ns / 1ps

module cnp_engine
#(
    parameter int POSITION_BITS = cnp_pkg::POSITION_BITS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             restart,
    input  logic                             proc,
    input  logic [cnp_pkg::BYTE_BITS-1:0]    byte_in,
    input  logic [cnp_pkg::LEN_BITS-1:0]     archive_length,
    input  logic [cnp_pkg::TYPE_BITS-1:0]    mode_type,
    input  logic [cnp_pkg::SIZE_BITS-1:0]    file_size,
    input  logic [cnp_pkg::SIZE_BITS-1:0]    name_size,
    input  cnp_pkg::cnp_bound_t              bound,
    output cnp_pkg::cnp_hdr_ctl_t            hdr_ctl,
    output logic [POSITION_BITS-1:0]         position,
    output logic                             res_valid,
    output cnp_pkg::cnp_result_t             res
);
    import cnp_pkg::*;

    localparam int LW = (POSITION_BITS > LEN_BITS) ? POSITION_BITS : LEN_BITS;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    cnp_phase_t               phase_reg, phase_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [VERDICT_BITS-1:0]  verdict_reg, verdict_next;
    logic                     root_pending_reg, root_pending_next;
    logic                     trailer_match_reg, trailer_match_next;
    logic                     emit_data_reg, emit_data_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [ALIGN_BITS-1:0]    pad;
    logic [LW-1:0]            len_ext;
    logic [LW-1:0]            pos_ext;
    logic                     beyond;
    logic                     short_hdr;
    cnp_phase_t               data_done_phase, data_entry_phase, name_done_phase;
    logic [CNT_BITS-1:0]      data_done_cnt, data_entry_cnt, name_done_cnt;
    logic [3:0]               trailer_idx;
    logic                     name_match;
    logic [VERDICT_BITS-1:0]  hdr_verdict;

    function automatic logic [BYTE_BITS-1:0] trailer_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return "T";
            4'd1:    return "R";
            4'd2:    return "A";
            4'd3:    return "I";
            4'd4:    return "L";
            4'd5:    return "E";
            4'd6:    return "R";
            4'd7:    return "!";
            4'd8:    return "!";
            4'd9:    return "!";
            default: return 8'h00;
        endcase
    endfunction

    always_comb
    begin
        pos_inc   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;
        pad       = ALIGN_BITS'(2'd0 - pos_inc[ALIGN_BITS-1:0]);
        len_ext   = LW'(archive_length);
        pos_ext   = LW'(pos_reg);
        beyond    = pos_ext >= len_ext;
        short_hdr = (len_ext - pos_ext) < LW'(HEADER_BYTES);

        if (pad != '0)
        begin
            data_done_phase = PH_DATA_PAD;
            data_done_cnt   = CNT_BITS'(pad);
        end
        else
        begin
            data_done_phase = PH_HEADER;
            data_done_cnt   = '0;
        end
        if (file_size != '0)
        begin
            data_entry_phase = PH_DATA;
            data_entry_cnt   = file_size;
        end
        else
        begin
            data_entry_phase = data_done_phase;
            data_entry_cnt   = data_done_cnt;
        end
        if (pad != '0)
        begin
            name_done_phase = PH_NAME_PAD;
            name_done_cnt   = CNT_BITS'(pad);
        end
        else
        begin
            name_done_phase = data_entry_phase;
            name_done_cnt   = data_entry_cnt;
        end

        trailer_idx = 4'(TRAILER_LEN) - cnt_reg[3:0];
        name_match  = trailer_match_reg && (trailer_idx < 4'(TRAILER_LEN)) &&
                      (byte_in == trailer_char(trailer_idx));

        if (name_size == '0)
        begin
            hdr_verdict = VD_IGNORED;
        end
        else if (mode_type == TYPE_DIR)
        begin
            hdr_verdict = root_pending_reg ? VD_IGNORED : VD_MKDIR;
        end
        else if (mode_type == TYPE_REG)
        begin
            hdr_verdict = bound.fits ? VD_FILE : VD_IGNORED;
        end
        else
        begin
            hdr_verdict = VD_IGNORED;
        end
    end

    always_comb
    begin
        pos_next           = pos_reg;
        phase_next         = phase_reg;
        cnt_next           = cnt_reg;
        verdict_next       = verdict_reg;
        root_pending_next  = root_pending_reg;
        trailer_match_next = trailer_match_reg;
        emit_data_next     = emit_data_reg;
        hdr_ctl.restart    = restart;
        hdr_ctl.step       = 1'b0;
        hdr_ctl.off        = cnt_reg[OFF_BITS-1:0];
        res_valid          = 1'b0;
        res.event_kind     = EV_STOP;
        res.byte_out       = '0;
        res.verdict        = verdict_reg;
        res.entry_file_size = file_size;
        res.entry_name_size = name_size;

        if (proc && phase_reg != PH_STOPPED)
        begin
            if (beyond)
            begin
                phase_next          = PH_STOPPED;
                res_valid           = 1'b1;
                res.verdict         = VD_SHORT;
                res.entry_file_size = '0;
                res.entry_name_size = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HEADER:
                    begin
                        if (cnt_reg == '0 && short_hdr)
                        begin
                            phase_next          = PH_STOPPED;
                            res_valid           = 1'b1;
                            res.verdict         = VD_SHORT;
                            res.entry_file_size = '0;
                            res.entry_name_size = '0;
                        end
                        else
                        begin
                            hdr_ctl.step = 1'b1;
                            pos_next     = pos_inc;
                            cnt_next     = cnt_reg + 1'b1;
                            if (cnt_reg == CNT_BITS'(HEADER_BYTES - 1))
                            begin
                                if (bound.overrun)
                                begin
                                    phase_next  = PH_STOPPED;
                                    res_valid   = 1'b1;
                                    res.verdict = VD_NAME_OVER;
                                end
                                else
                                begin
                                    verdict_next       = hdr_verdict;
                                    emit_data_next     = hdr_verdict == VD_FILE;
                                    trailer_match_next =
                                        name_size == SIZE_BITS'(TRAILER_LEN);
                                    if (name_size == '0)
                                    begin
                                        phase_next = name_done_phase;
                                        cnt_next   = name_done_cnt;
                                    end
                                    else
                                    begin
                                        phase_next = PH_NAME;
                                        cnt_next   = name_size;
                                    end
                                end
                            end
                        end
                    end
                    PH_NAME:
                    begin
                        trailer_match_next = name_match;
                        pos_next           = pos_inc;
                        cnt_next           = cnt_reg - 1'b1;
                        res_valid          = 1'b1;
                        res.byte_out       = byte_in;
                        if (cnt_reg != CNT_BITS'(1))
                        begin
                            res.event_kind = EV_NAME;
                        end
                        else if (name_match)
                        begin
                            phase_next     = PH_STOPPED;
                            res.event_kind = EV_NAME_LAST;
                            res.verdict    = VD_TRAILER;
                        end
                        else
                        begin
                            if (mode_type == TYPE_DIR)
                            begin
                                root_pending_next = 1'b0;
                            end
                            res.event_kind = EV_NAME_LAST;
                            phase_next     = name_done_phase;
                            cnt_next       = name_done_cnt;
                        end
                    end
                    PH_NAME_PAD:
                    begin
                        pos_next = pos_inc;
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == CNT_BITS'(1))
                        begin
                            phase_next = data_entry_phase;
                            cnt_next   = data_entry_cnt;
                        end
                    end
                    PH_DATA:
                    begin
                        pos_next = pos_inc;
                        cnt_next = cnt_reg - 1'b1;
                        if (emit_data_reg)
                        begin
                            res_valid      = 1'b1;
                            res.byte_out   = byte_in;
                            res.verdict    = VD_FILE;
                            res.event_kind = (cnt_reg == CNT_BITS'(1)) ? EV_DATA_LAST
                                                                       : EV_DATA;
                        end
                        if (cnt_reg == CNT_BITS'(1))
                        begin
                            phase_next = data_done_phase;
                            cnt_next   = data_done_cnt;
                        end
                    end
                    PH_DATA_PAD:
                    begin
                        pos_next = pos_inc;
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == CNT_BITS'(1))
                        begin
                            phase_next = PH_HEADER;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_STOPPED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg           <= '0;
            phase_reg         <= PH_HEADER;
            cnt_reg           <= '0;
            verdict_reg       <= VD_MKDIR;
            root_pending_reg  <= 1'b1;
            trailer_match_reg <= 1'b1;
            emit_data_reg     <= 1'b0;
        end
        else if (restart)
        begin
            pos_reg           <= '0;
            phase_reg         <= PH_HEADER;
            cnt_reg           <= '0;
            verdict_reg       <= VD_MKDIR;
            root_pending_reg  <= 1'b1;
            trailer_match_reg <= 1'b1;
            emit_data_reg     <= 1'b0;
        end
        else
        begin
            pos_reg           <= pos_next;
            phase_reg         <= phase_next;
            cnt_reg           <= cnt_next;
            verdict_reg       <= verdict_next;
            root_pending_reg  <= root_pending_next;
            trailer_match_reg <= trailer_match_next;
            emit_data_reg     <= emit_data_next;
        end
    end

    assign position = pos_reg;

endmodule

// ----- sv/cpio_newc_archive_parser.sv -----
// Each byte is registered at the input, and its result is registered at the output.
// Throughput: one archive byte per cycle while the output is not stalled; one header, name, data or pad step per byte.
// Each byte updates the phase counter and position, and a header byte the field accumulator, in one pass.
// Reset (rst_n low, asynchronous) and a write of archive_length restart parsing
// at byte position zero; archive_length itself resets to zero.
`timescale 1ns / 1ps

module cpio_newc_archive_parser
#(
    parameter int POSITION_BITS = cnp_pkg::POSITION_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cnp_pkg::LEN_BITS-1:0]      cfg_data,      // archive_length
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [cnp_pkg::BYTE_BITS-1:0]     s_axis_tdata,  // archive_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // byte_out, entry_file_size, entry_name_size
    output logic [cnp_pkg::TDATA_BITS-1:0]    m_axis_tdata,
    // event_kind, verdict
    output logic [cnp_pkg::TUSER_BITS-1:0]    m_axis_tuser
);
    import cnp_pkg::*;

    logic [LEN_BITS-1:0]      len_reg;
    logic                     in_valid_reg;
    logic [BYTE_BITS-1:0]     in_byte_reg;
    logic                     out_valid_reg;
    cnp_result_t              out_res_reg;
    logic                     restart;
    logic                     out_free;
    logic                     proc;
    cnp_hdr_ctl_t             hdr_ctl;
    cnp_bound_t               bound;
    logic [POSITION_BITS-1:0] position;
    logic [TYPE_BITS-1:0]     mode_type;
    logic [SIZE_BITS-1:0]     file_size;
    logic [SIZE_BITS-1:0]     name_size;
    logic                     res_valid;
    cnp_result_t              res;

    assign cfg_ready     = 1'b1;
    assign restart       = cfg_valid && cfg_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (restart)
            begin
                len_reg <= cfg_data;
            end
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= proc && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (proc && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    cnp_engine #(
        .POSITION_BITS(POSITION_BITS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .restart       (restart),
        .proc          (proc),
        .byte_in       (in_byte_reg),
        .archive_length(len_reg),
        .mode_type     (mode_type),
        .file_size     (file_size),
        .name_size     (name_size),
        .bound         (bound),
        .hdr_ctl       (hdr_ctl),
        .position      (position),
        .res_valid     (res_valid),
        .res           (res)
    );

    cnp_hex_field u_hex_field (
        .clk      (clk),
        .rst_n    (rst_n),
        .hdr_ctl  (hdr_ctl),
        .byte_in  (in_byte_reg),
        .mode_type(mode_type),
        .file_size(file_size),
        .name_size(name_size)
    );

    cnp_bound_calc #(
        .POSITION_BITS(POSITION_BITS)
    ) u_bound_calc (
        .clk           (clk),
        .hdr_ctl       (hdr_ctl),
        .position      (position),
        .name_size     (name_size),
        .file_size     (file_size),
        .archive_length(len_reg),
        .bound         (bound)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.entry_name_size, out_res_reg.entry_file_size,
                            out_res_reg.byte_out};
    assign m_axis_tuser  = {out_res_reg.verdict, out_res_reg.event_kind};

endmodule

// ----- sv/cnp_checker.sv -----
// Port-level checker of the archive parser and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cnp_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [cnp_pkg::TDATA_BITS-1:0]    m_axis_tdata,
    input  logic [cnp_pkg::TUSER_BITS-1:0]    m_axis_tuser
);
    import cnp_pkg::*;

    logic [KIND_BITS-1:0]    kind;
    logic [VERDICT_BITS-1:0] verdict;
    logic                    out_xact;
    logic                    last_word;

    assign kind      = m_axis_tuser[KIND_BITS-1:0];
    assign verdict   = m_axis_tuser[TUSER_BITS-1:KIND_BITS];
    assign out_xact  = m_axis_tvalid && m_axis_tready;
    assign last_word = (kind == EV_STOP) || (verdict == VD_TRAILER);

    `ASSERT_AT_CLK(a_codes_legal,
        m_axis_tvalid |-> (kind <= EV_STOP && verdict <= VD_NAME_OVER),
        "event kind or verdict out of range")

    `ASSERT_AT_CLK(a_short_is_bare_stop,
        (m_axis_tvalid && verdict == VD_SHORT) |->
        (kind == EV_STOP && m_axis_tdata == '0),
        "short header result must be a stop with zero payload")

    `ASSERT_AT_CLK(a_data_is_file,
        (m_axis_tvalid && (kind == EV_DATA || kind == EV_DATA_LAST)) |->
        (verdict == VD_FILE),
        "data byte without file verdict")

    `ASSERT_NEXT_CLK(a_quiet_after_stop, out_xact && last_word, !m_axis_tvalid,
        "result follows a stop or trailer transaction")

    `ASSERT_NEXT_CLK(a_hold_stalled, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result changed")

endmodule

bind cpio_newc_archive_parser cnp_checker u_cnp_checker (.*);
